### rtl/cisof_pkg.sv
// Shared package for the chord interval shift-or filter.
// Holds size defaults, action and state codes, payload and control structs.
// No dependencies.
package cisof_pkg;

  localparam int MAX_PATTERN      = 32;
  localparam int MAX_CHORD        = 16;
  localparam int INTERVAL_CLASSES = 12;

  localparam int ACTION_W    = 2;
  localparam int PITCH_W     = 7;
  localparam int LEN_W       = 6;
  localparam int CHORD_NUM_W = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2);

  typedef enum logic [ACTION_W-1:0] {
    ACT_FIRST   = 2'd0,
    ACT_NEXT    = 2'd1,
    ACT_CHORD   = 2'd2,
    ACT_RESTART = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PITCH_W-1:0]  pitch;
    logic                last_in_chord;
  } in_item_t;

  typedef struct packed {
    logic                   candidate;
    logic [CHORD_NUM_W-1:0] start_chord;
    logic [CHORD_NUM_W-1:0] chord_number;
    logic                   overflow;
  } out_item_t;

  // Sequencer to datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic issue;   // read one previous-chord note
    logic load;    // close the chord and load the result register
  } ctrl_cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic seen_first;
    logic prev_empty;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/cisof_chan.sv
// Valid/ready channel interface with a typed payload.
// Used for the input, result and configuration channels; no dependencies.
interface cisof_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/chord_interval_shift_or_filter.sv
// Top level of the chord interval shift-or filter.
// Depends on cisof_pkg, cisof_chan, cisof_ctrl, cisof_dpath (with cisof_ram).
//
//   channel  dir  payload                                     transfer when
//   in_i     in   action, pitch, last_in_chord                in_i.valid & in_i.ready
//   out_o    out  candidate, start_chord, chord_number, ovf   out_o.valid & out_o.ready
//   cfg_i    in   pattern_length (6 bits)                     cfg_i.valid & cfg_i.ready
//
// Pattern and restart items are taken in the idle state. A chord note goes on to
// a scan when a previous chord of P notes is stored (one note read per cycle, each
// folded into the accumulator), then to a drain state for the registered RAM read,
// and to a finish state when it ends its chord.
// The result register holds a result until taken; a chord close waits while it
// is full. No clearing pass after reset; cfg_i is always ready.
module chord_interval_shift_or_filter #(
  parameter int MaxPattern      = cisof_pkg::MAX_PATTERN,
  parameter int MaxChord        = cisof_pkg::MAX_CHORD,
  parameter int IntervalClasses = cisof_pkg::INTERVAL_CLASSES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cisof_chan.sink   in_i,
  cisof_chan.source out_o,
  cisof_chan.sink   cfg_i
);

  cisof_pkg::ctrl_cmd_t  cmd;
  cisof_pkg::dp_status_t status;
  cisof_pkg::in_item_t   in_data;

  assign in_data     = in_i.data;
  // The user must write the register only while idle; the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  // Sequencer: hold the input off while an item is at work.
  cisof_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_data.action),
    .in_last_i   (in_data.last_in_chord),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  // Datapath: mask table, note banks, accumulator, match word, result register.
  cisof_dpath #(
    .MaxPattern      (MaxPattern),
    .MaxChord        (MaxChord),
    .IntervalClasses (IntervalClasses)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .status_o   (status),
    .out_o      (out_o)
  );

endmodule

### rtl/cisof_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies beyond cisof_pkg for default sizes.
module cisof_ram #(
  parameter int Width = $clog2(cisof_pkg::INTERVAL_CLASSES),
  parameter int Depth = 2 * cisof_pkg::MAX_CHORD
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cisof_ctrl.sv
// Sequencer for the chord interval filter: accept, scan, drain, finish.
// Depends on cisof_pkg (state codes, command and status structs).
module cisof_ctrl (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic [cisof_pkg::ACTION_W-1:0]        in_action_i,
  input  logic                                  in_last_i,
  input  cisof_pkg::dp_status_t                 status_i,
  output logic                                  in_ready_o,
  output cisof_pkg::ctrl_cmd_t                  cmd_o
);

  cisof_pkg::state_e state_q, state_d;
  logic              last_q, last_d;
  logic              accept;

  assign in_ready_o = (state_q == cisof_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.accept = accept;
  assign cmd_o.issue  = (state_q == cisof_pkg::S_SCAN);
  assign cmd_o.load   = (state_q == cisof_pkg::S_FINISH) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    case (state_q)
      cisof_pkg::S_IDLE: begin
        if (accept && (in_action_i == cisof_pkg::ACT_CHORD)) begin
          last_d = in_last_i;
          if (status_i.seen_first && !status_i.prev_empty) begin
            state_d = cisof_pkg::S_SCAN;
          end else if (in_last_i) begin
            state_d = cisof_pkg::S_FINISH;
          end
        end
      end
      cisof_pkg::S_SCAN: begin
        if (status_i.scan_last) begin
          state_d = cisof_pkg::S_DRAIN;
        end
      end
      cisof_pkg::S_DRAIN: begin
        state_d = last_q ? cisof_pkg::S_FINISH : cisof_pkg::S_IDLE;
      end
      cisof_pkg::S_FINISH: begin
        if (status_i.out_free) begin
          state_d = cisof_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cisof_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cisof_pkg::S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

endmodule

### rtl/cisof_dpath.sv
// Datapath: interval mask table, note store, accumulator and match word.
// Depends on cisof_pkg, cisof_chan and cisof_ram.
module cisof_dpath #(
  parameter int MaxPattern      = cisof_pkg::MAX_PATTERN,
  parameter int MaxChord        = cisof_pkg::MAX_CHORD,
  parameter int IntervalClasses = cisof_pkg::INTERVAL_CLASSES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cisof_pkg::ctrl_cmd_t  cmd_i,
  input  cisof_pkg::in_item_t   in_data_i,
  input  logic                  cfg_we_i,
  input  cisof_pkg::len_t       cfg_data_i,
  output cisof_pkg::dp_status_t status_o,
  cisof_chan.source             out_o
);

  localparam int WordW    = MaxPattern - 1;
  localparam int LenW     = $clog2(MaxPattern + 1);
  localparam int SizeW    = $clog2(MaxChord + 1);
  localparam int AddrW    = $clog2(2 * MaxChord);
  localparam int ClassW   = $clog2(IntervalClasses);
  localparam int NumPitch = 2 ** cisof_pkg::PITCH_W;
  localparam int NumW     = cisof_pkg::CHORD_NUM_W;

  // Residue of every pitch, built by counting up with wrap.
  function automatic logic [NumPitch*ClassW-1:0] build_res();
    logic [NumPitch*ClassW-1:0] t;
    logic [ClassW-1:0]          r;
    t = '0;
    r = '0;
    for (int p = 0; p < NumPitch; p++) begin
      t[p*ClassW +: ClassW] = r;
      if (r == ClassW'(IntervalClasses - 1)) begin
        r = '0;
      end else begin
        r = r + ClassW'(1);
      end
    end
    return t;
  endfunction

  localparam logic [NumPitch*ClassW-1:0] ResTable = build_res();

  // Interval class from b up to a, both already reduced.
  function automatic logic [ClassW-1:0] class_diff(logic [ClassW-1:0] a,
                                                   logic [ClassW-1:0] b);
    logic [ClassW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (ClassW + 1)'(IntervalClasses) - {1'b0, b};
    end
    return s[ClassW-1:0];
  endfunction

  cisof_pkg::len_t   len_q;
  logic [WordW-1:0]  table_q [IntervalClasses];
  logic [WordW-1:0]  table_d [IntervalClasses];
  logic [LenW-1:0]   pcount_q, pcount_d;
  logic [ClassW-1:0] last_res_q, last_res_d;
  logic [ClassW-1:0] note_res_q, note_res_d;
  logic [SizeW-1:0]  prev_size_q, prev_size_d;
  logic [SizeW-1:0]  cur_size_q, cur_size_d;
  logic [SizeW-1:0]  idx_q, idx_d;
  logic              bank_q, bank_d;
  logic [WordW-1:0]  acc_q, acc_d;
  logic [WordW-1:0]  mw_q, mw_d;
  logic [NumW-1:0]   counter_q, counter_d;
  logic              seen_q, seen_d;
  logic              ovf_q, ovf_d;
  logic              rd_vld_q;
  logic              out_valid_q, out_valid_d;
  cisof_pkg::out_item_t out_data_q, out_data_d;

  logic [LenW-1:0]   eff_len;
  logic [ClassW-1:0] in_res;
  logic [ClassW-1:0] pat_diff;
  logic [ClassW-1:0] rd_data;
  logic [AddrW-1:0]  waddr, raddr;
  logic              wr_en;
  logic              restart;
  logic [WordW:0]    len_mask;
  logic [WordW:0]    mw_shift;
  logic [WordW-1:0]  mw_new;
  logic [WordW-1:0]  mw_probe;
  logic              hit;

  // Saturate the programmed length into 2..MaxPattern.
  always_comb begin
    if (int'(len_q) < 2) begin
      eff_len = LenW'(2);
    end else if (int'(len_q) > MaxPattern) begin
      eff_len = LenW'(MaxPattern);
    end else begin
      eff_len = LenW'(len_q);
    end
  end

  assign in_res   = ResTable[ClassW*in_data_i.pitch +: ClassW];
  assign pat_diff = class_diff(in_res, last_res_q);

  // Current chord is written to one bank while the other holds the previous one.
  assign waddr = bank_q ? AddrW'(MaxChord) + AddrW'(cur_size_q) : AddrW'(cur_size_q);
  assign raddr = bank_q ? AddrW'(idx_q) : AddrW'(MaxChord) + AddrW'(idx_q);
  assign wr_en = cmd_i.accept && (in_data_i.action == cisof_pkg::ACT_CHORD)
                 && (int'(cur_size_q) < MaxChord);

  cisof_ram #(
    .Width (ClassW),
    .Depth (2 * MaxChord)
  ) u_notes (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (in_res),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // Chord close: shift the accumulator into the match word.
  assign len_mask = ((WordW + 1)'(1) << (eff_len - LenW'(1))) - (WordW + 1)'(1);
  assign mw_shift = {mw_q, 1'b0} | {1'b0, acc_q};
  assign mw_new   = WordW'(mw_shift & len_mask);
  assign mw_probe = mw_new >> (eff_len - LenW'(2));
  assign hit      = seen_q && !mw_probe[0];

  always_comb begin
    table_d     = table_q;
    pcount_d    = pcount_q;
    last_res_d  = last_res_q;
    note_res_d  = note_res_q;
    prev_size_d = prev_size_q;
    cur_size_d  = cur_size_q;
    idx_d       = idx_q;
    bank_d      = bank_q;
    acc_d       = acc_q;
    mw_d        = mw_q;
    counter_d   = counter_q;
    seen_d      = seen_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    restart     = 1'b0;

    if (cmd_i.accept) begin
      case (in_data_i.action)
        cisof_pkg::ACT_FIRST: begin
          for (int k = 0; k < IntervalClasses; k++) begin
            table_d[k] = '1;
          end
          pcount_d   = LenW'(1);
          last_res_d = in_res;
          restart    = 1'b1;
        end
        cisof_pkg::ACT_NEXT: begin
          if (pcount_q == '0) begin
            pcount_d   = LenW'(1);
            last_res_d = in_res;
          end else if (pcount_q < eff_len) begin
            table_d[pat_diff] = table_q[pat_diff]
                                & ~(WordW'(1) << (pcount_q - LenW'(1)));
            last_res_d = in_res;
            pcount_d   = pcount_q + LenW'(1);
          end
        end
        cisof_pkg::ACT_CHORD: begin
          note_res_d = in_res;
          idx_d      = '0;
          if (int'(cur_size_q) < MaxChord) begin
            cur_size_d = cur_size_q + SizeW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        cisof_pkg::ACT_RESTART: begin
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
      if (restart) begin
        prev_size_d = '0;
        cur_size_d  = '0;
        acc_d       = '1;
        mw_d        = '1;
        counter_d   = '0;
        seen_d      = 1'b0;
        ovf_d       = 1'b0;
      end
    end

    if (cmd_i.issue) begin
      idx_d = idx_q + SizeW'(1);
    end

    // Fold one previous-chord interval into the accumulator.
    if (rd_vld_q) begin
      acc_d = acc_q & table_q[class_diff(note_res_q, rd_data)];
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      out_valid_d              = 1'b1;
      out_data_d.candidate     = hit;
      out_data_d.start_chord   = hit ? counter_q - NumW'(eff_len - LenW'(1)) : '0;
      out_data_d.chord_number  = counter_q;
      out_data_d.overflow      = ovf_q;
      if (seen_q) begin
        mw_d = mw_new;
      end
      prev_size_d = cur_size_q;
      cur_size_d  = '0;
      acc_d       = '1;
      ovf_d       = 1'b0;
      seen_d      = 1'b1;
      counter_d   = counter_q + NumW'(1);
      bank_d      = ~bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= cisof_pkg::LEN_RESET;
      for (int k = 0; k < IntervalClasses; k++) begin
        table_q[k] <= '1;
      end
      pcount_q    <= '0;
      last_res_q  <= '0;
      prev_size_q <= '0;
      cur_size_q  <= '0;
      idx_q       <= '0;
      bank_q      <= 1'b0;
      acc_q       <= '1;
      mw_q        <= '1;
      counter_q   <= '0;
      seen_q      <= 1'b0;
      ovf_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      table_q     <= table_d;
      pcount_q    <= pcount_d;
      last_res_q  <= last_res_d;
      prev_size_q <= prev_size_d;
      cur_size_q  <= cur_size_d;
      idx_q       <= idx_d;
      bank_q      <= bank_d;
      acc_q       <= acc_d;
      mw_q        <= mw_d;
      counter_q   <= counter_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      rd_vld_q    <= cmd_i.issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    note_res_q <= note_res_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign status_o.seen_first = seen_q;
  assign status_o.prev_empty = (prev_size_q == '0);
  assign status_o.scan_last  = ((idx_q + SizeW'(1)) == prev_size_q);
  assign status_o.out_free   = !out_valid_q || out_o.ready;

  // No new item while a note read is still in flight.
  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> !cmd_i.accept)
    else $error("input transfer while a note read is pending");

  // The last fold must land before the chord closes.
  a_load_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !rd_vld_q && !cmd_i.issue)
    else $error("chord closed with a fold outstanding");

  // A read never goes past the stored previous chord.
  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (idx_q < prev_size_q) && seen_q)
    else $error("note read beyond previous chord size");

  // Closing a chord leaves a result and marks the first chord seen.
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q && seen_q && (cur_size_q == '0))
    else $error("chord close did not produce a result");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(cur_size_q) <= MaxChord) && (int'(prev_size_q) <= MaxChord))
    else $error("chord size above capacity");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for chord_interval_shift_or_filter: directed and random stimulus
// checked against a local shift-or melody predictor held in a scoreboard class.
// Depends on cisof_pkg, cisof_chan and the filter RTL.
module tb;

  localparam logic [63:0] WORD_ONES = 64'h7FFF_FFFF;
  localparam int unsigned QUIET_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 300_000;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  // Predicts chord results of the shift-or interval filter and checks them.
  class melody_match_scoreboard;
    logic [63:0]  itab [cisof_pkg::INTERVAL_CLASSES];
    int unsigned  pat_count;
    logic [6:0]   pat_last;
    logic [6:0]   prev_notes [cisof_pkg::MAX_CHORD];
    logic [6:0]   cur_notes [cisof_pkg::MAX_CHORD];
    int unsigned  prev_size;
    int unsigned  cur_size;
    logic [63:0]  acc;
    logic [63:0]  mword;
    logic [31:0]  chord_cnt;
    logic         seen;
    logic         ovf;
    cisof_pkg::len_t      plen;
    cisof_pkg::out_item_t expected_chords [$];
    int unsigned  mismatches;

    function new();
      foreach (itab[k]) itab[k] = WORD_ONES;
      pat_count = 0;
      pat_last = '0;
      plen = cisof_pkg::LEN_RESET;
      mismatches = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      prev_size = 0;
      cur_size = 0;
      acc = WORD_ONES;
      mword = WORD_ONES;
      chord_cnt = '0;
      seen = 1'b0;
      ovf = 1'b0;
      foreach (prev_notes[k]) prev_notes[k] = '0;
      foreach (cur_notes[k]) cur_notes[k] = '0;
    endfunction

    function void set_length(cisof_pkg::len_t v);
      plen = v;
    endfunction

    function int unsigned eff_len();
      if (plen < 2) return 2;
      if (plen > cisof_pkg::MAX_PATTERN) return cisof_pkg::MAX_PATTERN;
      return plen;
    endfunction

    function int unsigned interval(logic [6:0] to_p, logic [6:0] from_p);
      return ((to_p % cisof_pkg::INTERVAL_CLASSES) + cisof_pkg::INTERVAL_CLASSES
              - (from_p % cisof_pkg::INTERVAL_CLASSES)) % cisof_pkg::INTERVAL_CLASSES;
    endfunction

    function void note_item(cisof_pkg::in_item_t it);
      int unsigned m;
      int unsigned d;
      logic [63:0] mask;
      cisof_pkg::out_item_t res;
      m = eff_len();
      case (it.action)
        cisof_pkg::ACT_FIRST, cisof_pkg::ACT_RESTART: begin
          if (it.action == cisof_pkg::ACT_FIRST) begin
            foreach (itab[k]) itab[k] = WORD_ONES;
            pat_count = 1;
            pat_last = it.pitch;
          end
          clear_scan();
        end
        cisof_pkg::ACT_NEXT: begin
          if (pat_count == 0) begin
            pat_count = 1;
            pat_last = it.pitch;
          end else if (pat_count < m) begin
            d = interval(it.pitch, pat_last);
            itab[d][pat_count-1] = 1'b0;
            pat_last = it.pitch;
            pat_count++;
          end
        end
        default: begin
          if (seen) begin
            for (int unsigned i = 0; i < prev_size; i++)
              acc &= itab[interval(it.pitch, prev_notes[i])];
          end
          if (cur_size < cisof_pkg::MAX_CHORD) begin
            cur_notes[cur_size] = it.pitch;
            cur_size++;
          end else begin
            ovf = 1'b1;
          end
          if (it.last_in_chord) begin
            mask = (64'd1 << (m - 1)) - 64'd1;
            res = '0;
            if (seen) begin
              mword = ((mword << 1) | acc) & mask;
              if (mword[m-2] == 1'b0) begin
                res.candidate = 1'b1;
                res.start_chord = chord_cnt - 32'(m - 1);
              end
            end
            res.chord_number = chord_cnt;
            res.overflow = ovf;
            expected_chords.push_back(res);
            prev_notes = cur_notes;
            prev_size = cur_size;
            cur_size = 0;
            acc = WORD_ONES;
            ovf = 1'b0;
            seen = 1'b1;
            chord_cnt++;
          end
        end
      endcase
    endfunction

    function void check_chord_result(cisof_pkg::out_item_t got);
      cisof_pkg::out_item_t want;
      if (expected_chords.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected result: cand=%0d start=%0d chord=%0d ovf=%0d",
                   got.candidate, got.start_chord, got.chord_number, got.overflow);
        return;
      end
      want = expected_chords.pop_front();
      if (got.candidate !== want.candidate || got.start_chord !== want.start_chord ||
          got.chord_number !== want.chord_number || got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("mismatch: exp c=%0d s=%0d n=%0d o=%0d, got c=%0d s=%0d n=%0d o=%0d",
                   want.candidate, want.start_chord, want.chord_number, want.overflow,
                   got.candidate, got.start_chord, got.chord_number, got.overflow);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned in_calm = 0;
  int unsigned out_calm = 0;
  melody_match_scoreboard sb = new();

  cisof_chan #(.T(cisof_pkg::in_item_t))  in_ch ();
  cisof_chan #(.T(cisof_pkg::out_item_t)) out_ch ();
  cisof_chan #(.T(cisof_pkg::len_t))      cfg_ch ();

  chord_interval_shift_or_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Draw an idle count from 0 to 8, with occasional stretches of back-to-back transfers.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, 8);
  endfunction

  // Drive one input item and hold it until the transfer. Valid stays high
  // when no gap follows, so it never drops and rises in one time step.
  task automatic send_item(cisof_pkg::action_e act, logic [6:0] p, logic last);
    int unsigned gap;
    cisof_pkg::in_item_t it;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.action = act;
    it.pitch = p;
    it.last_in_chord = last;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(it);
    sent++;
  endtask

  // Send one chord of random notes; optionally plant one given pitch in it.
  // About one chord in twenty fills the note store, and most of those overrun it.
  task automatic send_chord(logic tie, logic [6:0] tie_pitch);
    int unsigned size;
    int unsigned at;
    logic [6:0] p;
    size = ($urandom_range(0, 19) == 0)
           ? $urandom_range(cisof_pkg::MAX_CHORD, cisof_pkg::MAX_CHORD + 2)
           : $urandom_range(1, 4);
    at = $urandom_range(0, size - 1);
    for (int unsigned k = 0; k < size; k++) begin
      p = (tie && k == at) ? tie_pitch : 7'($urandom_range(0, 127));
      send_item(cisof_pkg::ACT_CHORD, p, k == size - 1);
    end
  endtask

  // Wait until every expected result is taken, then let the block settle.
  task automatic wait_quiet();
    while (sb.expected_chords.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Write pattern_length while the block is idle.
  task automatic write_length(cisof_pkg::len_t v);
    in_ch.valid <= 1'b0;
    wait_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_length(v);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: stall at random, then take and check each transfer.
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_wait(out_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      sb.check_chord_result(out_ch.data);
    end
  end

  initial begin : stimulus
    cisof_pkg::len_t phase_len [9];
    logic [6:0] pat [cisof_pkg::MAX_PATTERN + 2];
    int unsigned start;
    int unsigned m;
    int unsigned n;
    int unsigned shift;
    int unsigned r;
    logic [6:0] tie_pitch;

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = cisof_pkg::LEN_RESET;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset pattern length of two.
    // Take a next pitch before any first pitch as the first; ignore its last flag.
    send_item(cisof_pkg::ACT_NEXT, 7'd127, 1'b1);
    send_item(cisof_pkg::ACT_NEXT, 7'd0, 1'b0);
    // Drop a pattern pitch beyond the pattern length.
    send_item(cisof_pkg::ACT_NEXT, 7'd64, 1'b1);
    // First chord is only stored; then a chord whose interval misses the pattern.
    send_item(cisof_pkg::ACT_CHORD, 7'd0, 1'b1);
    send_item(cisof_pkg::ACT_CHORD, 7'd127, 1'b1);
    // Overrun the note store by one note.
    for (int unsigned k = 0; k <= cisof_pkg::MAX_CHORD; k++)
      send_item(cisof_pkg::ACT_CHORD, k[0] ? 7'd127 : 7'd0, k == cisof_pkg::MAX_CHORD);
    send_item(cisof_pkg::ACT_CHORD, 7'd5, 1'b1);
    // Restart the scan with the last flag set, then start over.
    send_item(cisof_pkg::ACT_RESTART, 7'd127, 1'b1);
    send_item(cisof_pkg::ACT_CHORD, 7'd127, 1'b1);
    send_item(cisof_pkg::ACT_CHORD, 7'd0, 1'b1);
    // Load a one-pitch pattern: its interval is never loaded, so nothing matches.
    send_item(cisof_pkg::ACT_FIRST, 7'd127, 1'b1);
    send_item(cisof_pkg::ACT_CHORD, 7'd0, 1'b0);
    send_item(cisof_pkg::ACT_CHORD, 7'd127, 1'b1);
    send_item(cisof_pkg::ACT_CHORD, 7'd7, 1'b1);

    // Random part: one phase per pattern length, extremes and saturation included.
    phase_len = '{6'd32, 6'd3, 6'd0, 6'd63, 6'd1, 6'd5, 6'd17, 6'd2, 6'd2};
    phase_len[7] = cisof_pkg::len_t'($urandom_range(0, 63));
    phase_len[8] = cisof_pkg::len_t'($urandom_range(0, 63));
    foreach (phase_len[ph]) begin
      write_length(phase_len[ph]);
      start = sent;
      // Continue the old scan under the new length before reloading.
      repeat (2) send_chord(1'b0, 7'd0);
      while (sent - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 9);
        if (r < 8) begin
          // Load a pattern (sometimes short, sometimes too long), then play it
          // transposed through consecutive chords among random chords.
          m = sb.eff_len();
          case ($urandom_range(0, 9))
            0:       n = m - 1;
            1:       n = m + 2;
            default: n = m;
          endcase
          for (int unsigned k = 0; k < n; k++) pat[k] = 7'($urandom_range(0, 127));
          send_item(cisof_pkg::ACT_FIRST, pat[0], 1'($urandom_range(0, 1)));
          for (int unsigned k = 1; k < n; k++)
            send_item(cisof_pkg::ACT_NEXT, pat[k], 1'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 3)) send_chord(1'b0, 7'd0);
          shift = $urandom_range(0, 11);
          for (int unsigned k = 0; k < n && k < m; k++) begin
            tie_pitch = 7'((pat[k] + shift) % 12 + 12 * $urandom_range(0, 9));
            send_chord(1'b1, tie_pitch);
          end
          repeat ($urandom_range(0, 2)) send_chord(1'b0, 7'd0);
        end else begin
          // Noise: any action, pitch and flag, weighted toward chord notes.
          repeat ($urandom_range(4, 12)) begin
            send_item($urandom_range(0, 1) ? cisof_pkg::ACT_CHORD
                                           : cisof_pkg::action_e'($urandom_range(0, 3)),
                      7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
          end
        end
      end
    end

    in_ch.valid <= 1'b0;
    wait_quiet();
    if (sb.mismatches == 0 && sb.expected_chords.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
